// File: rtl/core/krfp_pkg.sv
// Package for the keyed record field parser: character codes, result kinds,
// register indexes and default parameter values. No dependencies.
`default_nettype none

package krfp_pkg;

    // Default sizing of the parser
    localparam int MAX_RECORDS_DEF = 8;
    localparam int MAX_FIELDS_DEF  = 5;
    localparam int VALUE_BITS_DEF  = 32;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int INDEX_W     = 3;
    localparam int REC_CNT_W   = 4;
    localparam int FLD_CNT_W   = 3;
    localparam int KEYS_W      = 64;
    localparam int TAGS_W      = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_KEYS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_TAGS   = 2'd3;

    // Register reset values
    localparam logic [REC_CNT_W-1:0] RECORD_COUNT_RST = 4'd1;
    localparam logic [FLD_CNT_W-1:0] FIELD_COUNT_RST  = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CONSUMED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HDR_ERR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_Y_ABORT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MISMATCH  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD_DIGIT = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ECHO      = 3'd6;
    localparam logic [KIND_W-1:0] KIND_REBOOT    = 3'd7;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_HEADER = 8'h52; // R
    localparam logic [BYTE_W-1:0] CH_ABORT  = 8'h59; // Y
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B; // +
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D; // -
    localparam logic [BYTE_W-1:0] CH_REBOOT = 8'h5A; // Z
    localparam logic [BYTE_W-1:0] CH_ECHO   = 8'h4E; // N
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30; // 0
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39; // 9

endpackage

`default_nettype wire

// File: rtl/core/keyed_record_field_parser_unit.sv
// Keyed record field parser top level: input word register, parse logic and
// result register. Depends on krfp_pkg.
`default_nettype none

// The parser takes one received character per word and returns exactly one
// result word for each, in order. It accepts a new word every clock cycle
// while the output side is not stalled; each word is held in the input
// register and then lands in the result register, from which it can be
// taken when the output side is not stalled. The phase, record/field
// counters and the multiply-by-ten accumulator are updated together as
// each character moves from the input register to the result register.
// Configuration writes are always taken (ready is tied high) and must only
// be made while the parser is idle.
module keyed_record_field_parser_unit #(
    parameter int MAX_RECORDS = krfp_pkg::MAX_RECORDS_DEF,
    parameter int MAX_FIELDS  = krfp_pkg::MAX_FIELDS_DEF,
    parameter int VALUE_BITS  = krfp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // character input
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [krfp_pkg::BYTE_W-1:0]         i_rx_byte,
    // result output
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [krfp_pkg::KIND_W-1:0]              o_kind,
    output logic [krfp_pkg::INDEX_W-1:0]             o_record_index,
    output logic [krfp_pkg::INDEX_W-1:0]             o_field_index,
    output logic signed [VALUE_BITS-1:0]             o_value,
    output logic                                     o_frame_done,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [krfp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [krfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ACC_W  = VALUE_BITS - 1;
    localparam int WIDE_W = VALUE_BITS + 3;

    localparam logic [krfp_pkg::REC_CNT_W-1:0] MAX_REC_C =
        krfp_pkg::REC_CNT_W'(MAX_RECORDS);
    localparam logic [krfp_pkg::FLD_CNT_W-1:0] MAX_FLD_C =
        krfp_pkg::FLD_CNT_W'(MAX_FIELDS);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_KEY    = 2'd1,
        PH_TAG    = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    // Configuration registers
    logic [krfp_pkg::REC_CNT_W-1:0] r_record_count;
    logic [krfp_pkg::FLD_CNT_W-1:0] r_field_count;
    logic [krfp_pkg::KEYS_W-1:0]    r_record_keys;
    logic [krfp_pkg::TAGS_W-1:0]    r_field_tags;

    // Parse state
    t_phase                        r_phase,  n_phase;
    logic [krfp_pkg::INDEX_W-1:0]  r_rec_cnt, n_rec_cnt;
    logic [krfp_pkg::INDEX_W-1:0]  r_fld_cnt, n_fld_cnt;
    logic [ACC_W-1:0]              r_acc,    n_acc;

    // Input word register
    logic                          r_in_valid;
    logic [krfp_pkg::BYTE_W-1:0]   r_in_byte;

    // Result register
    logic                          r_out_valid;
    logic [krfp_pkg::KIND_W-1:0]   r_kind,   n_kind;
    logic [krfp_pkg::INDEX_W-1:0]  r_rix,    n_rix;
    logic [krfp_pkg::INDEX_W-1:0]  r_fix,    n_fix;
    logic [VALUE_BITS-1:0]         r_value,  n_value;
    logic                          r_done,   n_done;

    logic                          advance;
    logic                          in_accept;
    logic [krfp_pkg::REC_CNT_W-1:0] used_records;
    logic [krfp_pkg::FLD_CNT_W-1:0] used_fields;
    logic [krfp_pkg::BYTE_W-1:0]   key_char;
    logic [krfp_pkg::BYTE_W-1:0]   tag_char;
    logic                          is_digit;
    logic [WIDE_W-1:0]             acc_wide;
    logic [WIDE_W-1:0]             acc_next_wide;
    logic                          acc_sat;
    logic [krfp_pkg::REC_CNT_W-1:0] rec_inc;
    logic [krfp_pkg::REC_CNT_W-1:0] fld_inc;

    // Handshake: move the input word on when the result slot is free
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Clamp configured counts to the sizing
    assign used_records = (r_record_count > MAX_REC_C) ? MAX_REC_C : r_record_count;
    assign used_fields  = (r_field_count > MAX_FLD_C) ? MAX_FLD_C : r_field_count;

    // Expected key and tag characters
    assign key_char = r_record_keys[{r_rec_cnt, 3'b000} +: krfp_pkg::BYTE_W];
    assign tag_char = (r_fld_cnt > 3'd4) ? '0
                    : r_field_tags[{r_fld_cnt, 3'b000} +: krfp_pkg::BYTE_W];

    // Multiply-by-ten accumulate with saturation at the largest magnitude
    assign is_digit      = (r_in_byte >= krfp_pkg::CH_ZERO) && (r_in_byte <= krfp_pkg::CH_NINE);
    assign acc_wide      = WIDE_W'(r_acc);
    assign acc_next_wide = (acc_wide << 3) + (acc_wide << 1)
                         + WIDE_W'(r_in_byte[3:0]);
    assign acc_sat       = acc_next_wide > WIDE_W'({ACC_W{1'b1}});

    // Counter increments with room for the carry
    assign rec_inc = krfp_pkg::REC_CNT_W'(r_rec_cnt) + 4'd1;
    assign fld_inc = krfp_pkg::REC_CNT_W'(r_fld_cnt) + 4'd1;

    // Parse one character
    always_comb begin
        n_phase   = r_phase;
        n_rec_cnt = r_rec_cnt;
        n_fld_cnt = r_fld_cnt;
        n_acc     = r_acc;
        n_kind    = krfp_pkg::KIND_CONSUMED;
        n_rix     = '0;
        n_fix     = '0;
        n_value   = '0;
        n_done    = 1'b0;

        if (r_in_byte == krfp_pkg::CH_REBOOT) begin
            n_kind    = krfp_pkg::KIND_REBOOT;
            n_phase   = PH_HEADER;
            n_rec_cnt = '0;
            n_fld_cnt = '0;
            n_acc     = '0;
        end else if (r_in_byte == krfp_pkg::CH_ECHO) begin
            n_kind = krfp_pkg::KIND_ECHO;
        end else if (r_phase == PH_HEADER) begin
            // a wrong header is flagged, parsing goes on regardless
            n_kind    = (r_in_byte == krfp_pkg::CH_HEADER) ? krfp_pkg::KIND_CONSUMED
                                                           : krfp_pkg::KIND_HDR_ERR;
            n_rec_cnt = '0;
            n_fld_cnt = '0;
            n_acc     = '0;
            if (used_records == '0 || used_fields == '0) begin
                n_done  = 1'b1;
                n_phase = PH_HEADER;
            end else begin
                n_phase = PH_KEY;
            end
        end else if (r_in_byte == krfp_pkg::CH_ABORT) begin
            n_kind    = krfp_pkg::KIND_Y_ABORT;
            n_phase   = PH_HEADER;
            n_rec_cnt = '0;
            n_fld_cnt = '0;
            n_acc     = '0;
        end else if (r_phase == PH_KEY || r_phase == PH_TAG) begin
            if (r_in_byte != ((r_phase == PH_KEY) ? key_char : tag_char)) begin
                n_kind    = krfp_pkg::KIND_MISMATCH;
                n_phase   = PH_HEADER;
                n_rec_cnt = '0;
                n_fld_cnt = '0;
                n_acc     = '0;
            end else if (r_phase == PH_KEY) begin
                n_phase = PH_TAG;
            end else begin
                n_phase = PH_DIGITS;
                n_acc   = '0;
            end
        end else if (r_in_byte == krfp_pkg::CH_PLUS || r_in_byte == krfp_pkg::CH_MINUS) begin
            // finish the value and step to the next field or record
            n_kind    = krfp_pkg::KIND_VALUE;
            n_rix     = r_rec_cnt;
            n_fix     = r_fld_cnt;
            n_value   = (r_in_byte == krfp_pkg::CH_MINUS)
                      ? VALUE_BITS'(0) - VALUE_BITS'(r_acc)
                      : VALUE_BITS'(r_acc);
            n_acc     = '0;
            n_phase   = PH_KEY;
            n_fld_cnt = fld_inc[krfp_pkg::INDEX_W-1:0];
            if (fld_inc >= krfp_pkg::REC_CNT_W'(used_fields)) begin
                n_fld_cnt = '0;
                n_rec_cnt = rec_inc[krfp_pkg::INDEX_W-1:0];
                if (rec_inc >= used_records) begin
                    n_done    = 1'b1;
                    n_phase   = PH_HEADER;
                    n_rec_cnt = '0;
                end
            end
        end else if (is_digit) begin
            n_acc = acc_sat ? {ACC_W{1'b1}} : acc_next_wide[ACC_W-1:0];
        end else begin
            n_kind    = krfp_pkg::KIND_BAD_DIGIT;
            n_phase   = PH_HEADER;
            n_rec_cnt = '0;
            n_fld_cnt = '0;
            n_acc     = '0;
        end
    end

    // Hold configuration, parse state, input word and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_count <= krfp_pkg::RECORD_COUNT_RST;
            r_field_count  <= krfp_pkg::FIELD_COUNT_RST;
            r_record_keys  <= '0;
            r_field_tags   <= '0;
            r_phase        <= PH_HEADER;
            r_rec_cnt      <= '0;
            r_fld_cnt      <= '0;
            r_acc          <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    krfp_pkg::REG_RECORD_COUNT:
                        r_record_count <= i_cfg_data[krfp_pkg::REC_CNT_W-1:0];
                    krfp_pkg::REG_FIELD_COUNT:
                        r_field_count <= i_cfg_data[krfp_pkg::FLD_CNT_W-1:0];
                    krfp_pkg::REG_RECORD_KEYS:
                        r_record_keys <= i_cfg_data[krfp_pkg::KEYS_W-1:0];
                    krfp_pkg::REG_FIELD_TAGS:
                        r_field_tags <= i_cfg_data[krfp_pkg::TAGS_W-1:0];
                    default: ;
                endcase
            end

            // input word register
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_rx_byte;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            // parse step and result load
            if (advance) begin
                r_phase     <= n_phase;
                r_rec_cnt   <= n_rec_cnt;
                r_fld_cnt   <= n_fld_cnt;
                r_acc       <= n_acc;
                r_out_valid <= 1'b1;
                r_kind      <= n_kind;
                r_rix       <= n_rix;
                r_fix       <= n_fix;
                r_value     <= n_value;
                r_done      <= n_done;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_record_index = r_rix;
    assign o_field_index  = r_fix;
    assign o_value        = r_value;
    assign o_frame_done   = r_done;

endmodule

`default_nettype wire

// File: bench/krfp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the keyed record field parser: mirrors register writes,
// predicts one result word per accepted character and compares them in order.
// Depends on krfp_pkg.
module krfp_result_checker #(
    parameter int MAX_RECORDS = krfp_pkg::MAX_RECORDS_DEF,
    parameter int MAX_FIELDS  = krfp_pkg::MAX_FIELDS_DEF,
    parameter int VALUE_BITS  = krfp_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [krfp_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [krfp_pkg::KIND_W-1:0]       i_kind,
    input  logic [krfp_pkg::INDEX_W-1:0]      i_record_index,
    input  logic [krfp_pkg::INDEX_W-1:0]      i_field_index,
    input  logic signed [VALUE_BITS-1:0]      i_value,
    input  logic                              i_frame_done,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [krfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [krfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_mismatch_count,
    output int                                o_pending,
    output int                                o_result_count,
    output int                                o_value_count
);
    import krfp_pkg::*;

    typedef enum logic [1:0] {AWAIT_HEADER, AWAIT_KEY, AWAIT_TAG, IN_DIGITS} parse_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [INDEX_W-1:0]    rec;
        logic [INDEX_W-1:0]    fld;
        logic [VALUE_BITS-1:0] value;
        logic                  done;
    } result_word_t;

    localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

    // Register mirror
    logic [REC_CNT_W-1:0] rec_count_q;
    logic [FLD_CNT_W-1:0] fld_count_q;
    logic [KEYS_W-1:0]    keys_q;
    logic [TAGS_W-1:0]    tags_q;

    // Parse state
    parse_phase_t phase_q;
    int unsigned  rec_ctr;
    int unsigned  fld_ctr;
    logic [63:0]  mag_acc;

    result_word_t expected_words[$];

    function automatic void restart_parse();
        phase_q = AWAIT_HEADER;
        rec_ctr = 0;
        fld_ctr = 0;
        mag_acc = '0;
    endfunction

    // Advance the parse by one character and return the word it should produce
    function automatic result_word_t parse_char(input logic [BYTE_W-1:0] c);
        result_word_t res;
        int unsigned  n_rec;
        int unsigned  n_fld;
        logic [7:0]   want;
        logic [63:0]  digit;
        res   = '0;
        n_rec = (rec_count_q > MAX_RECORDS) ? MAX_RECORDS : rec_count_q;
        n_fld = (fld_count_q > MAX_FIELDS) ? MAX_FIELDS : fld_count_q;
        if (c == CH_REBOOT) begin
            res.kind = KIND_REBOOT;
            restart_parse();
        end else if (c == CH_ECHO) begin
            res.kind = KIND_ECHO;
        end else if (phase_q == AWAIT_HEADER) begin
            // any header byte opens a frame; only 'R' is clean
            res.kind = (c == CH_HEADER) ? KIND_CONSUMED : KIND_HDR_ERR;
            rec_ctr  = 0;
            fld_ctr  = 0;
            mag_acc  = '0;
            if (n_rec == 0 || n_fld == 0) begin
                res.done = 1'b1;
                phase_q  = AWAIT_HEADER;
            end else begin
                phase_q = AWAIT_KEY;
            end
        end else if (c == CH_ABORT) begin
            res.kind = KIND_Y_ABORT;
            restart_parse();
        end else if (phase_q == AWAIT_KEY) begin
            want = keys_q[(rec_ctr % 8) * 8 +: 8];
            if (c != want) begin
                res.kind = KIND_MISMATCH;
                restart_parse();
            end else begin
                phase_q = AWAIT_TAG;
            end
        end else if (phase_q == AWAIT_TAG) begin
            if (fld_ctr > 4)
                want = 8'h00;
            else
                want = tags_q[fld_ctr * 8 +: 8];
            if (c != want) begin
                res.kind = KIND_MISMATCH;
                restart_parse();
            end else begin
                phase_q = IN_DIGITS;
                mag_acc = '0;
            end
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            // finish the value and step to the next field slot
            res.kind  = KIND_VALUE;
            res.rec   = rec_ctr[INDEX_W-1:0];
            res.fld   = fld_ctr[INDEX_W-1:0];
            res.value = (c == CH_MINUS) ? VALUE_BITS'(64'd0 - mag_acc) : VALUE_BITS'(mag_acc);
            mag_acc   = '0;
            fld_ctr++;
            phase_q   = AWAIT_KEY;
            if (fld_ctr >= n_fld) begin
                fld_ctr = 0;
                rec_ctr++;
                if (rec_ctr >= n_rec) begin
                    res.done = 1'b1;
                    restart_parse();
                end
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            // accumulate, saturating at the largest magnitude
            digit = {56'd0, c - CH_ZERO};
            if (mag_acc > (MAG_LIMIT - digit) / 64'd10)
                mag_acc = MAG_LIMIT;
            else
                mag_acc = mag_acc * 64'd10 + digit;
        end else begin
            res.kind = KIND_BAD_DIGIT;
            restart_parse();
        end
        return res;
    endfunction

    function automatic void check_field(input string what, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: result %0d, %s expected %0d, actual %0d",
                     $time, o_result_count, what, want, got);
            o_mismatch_count++;
        end
    endfunction

    // Track writes, predict on accepted characters, compare accepted results
    always @(posedge i_clk) begin
        result_word_t want;
        if (!i_rst_n) begin
            rec_count_q = RECORD_COUNT_RST;
            fld_count_q = FIELD_COUNT_RST;
            keys_q      = '0;
            tags_q      = '0;
            restart_parse();
            expected_words.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RECORD_COUNT: rec_count_q = i_cfg_data[REC_CNT_W-1:0];
                    REG_FIELD_COUNT:  fld_count_q = i_cfg_data[FLD_CNT_W-1:0];
                    REG_RECORD_KEYS:  keys_q      = i_cfg_data[KEYS_W-1:0];
                    REG_FIELD_TAGS:   tags_q      = i_cfg_data[TAGS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(parse_char(i_rx_byte));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected, kind %0d value %0d",
                             $time, i_kind, i_value);
                    o_mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("kind", {61'd0, want.kind}, {61'd0, i_kind});
                    check_field("record_index", {61'd0, want.rec}, {61'd0, i_record_index});
                    check_field("field_index", {61'd0, want.fld}, {61'd0, i_field_index});
                    check_field("value", 64'($signed(want.value)), 64'(i_value));
                    check_field("frame_done", {63'd0, want.done}, {63'd0, i_frame_done});
                    if (want.kind == KIND_VALUE)
                        o_value_count++;
                end
                o_result_count++;
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

// File: bench/tb_keyed_record_field_parser_unit.sv
`timescale 1ns / 1ps
// Testbench top for keyed_record_field_parser_unit: clock, reset, register
// settings, character stimulus and output stalls. Depends on krfp_pkg and
// krfp_result_checker.
module tb_keyed_record_field_parser_unit;
    import krfp_pkg::*;

    localparam int     MAX_REC         = MAX_RECORDS_DEF;
    localparam int     MAX_FLD         = MAX_FIELDS_DEF;
    localparam int     VAL_W           = VALUE_BITS_DEF;
    localparam int     NUM_SETTINGS    = 10;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     DRAIN_CYCLES    = 4;
    localparam longint TIMEOUT_NS      = 10_000_000;

    // Characters of the directed frame
    localparam logic [BYTE_W-1:0] KEY_K = 8'h6B; // k
    localparam logic [BYTE_W-1:0] TAG_P = 8'h70; // p
    localparam logic [BYTE_W-1:0] TAG_Q = 8'h71; // q

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]        i_rx_byte   = '0;
    logic                     i_out_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [KIND_W-1:0]        o_kind;
    logic [INDEX_W-1:0]       o_record_index;
    logic [INDEX_W-1:0]       o_field_index;
    logic signed [VAL_W-1:0]  o_value;
    logic                     o_frame_done;
    logic                     o_cfg_ready;

    int mismatches;
    int pending;
    int results_seen;
    int values_seen;

    // Stimulus-side copy of the current setting
    logic [REC_CNT_W-1:0] cur_rec_count;
    logic [FLD_CNT_W-1:0] cur_fld_count;
    logic [KEYS_W-1:0]    cur_keys;
    logic [TAGS_W-1:0]    cur_tags;

    int sent_count     = 0;
    int settings_count = 0;
    int burst_left     = 0;
    bit hold_off_req   = 1'b0;
    bit hold_off_done  = 1'b0;

    keyed_record_field_parser_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_record_index (o_record_index),
        .o_field_index  (o_field_index),
        .o_value        (o_value),
        .o_frame_done   (o_frame_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    krfp_result_checker result_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_kind           (o_kind),
        .i_record_index   (o_record_index),
        .i_field_index    (o_field_index),
        .i_value          (o_value),
        .i_frame_done     (o_frame_done),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatches),
        .o_pending        (pending),
        .o_result_count   (results_seen),
        .o_value_count    (values_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Any byte that can match a key or tag: not reboot, echo or abort
    function automatic logic [BYTE_W-1:0] pick_char();
        logic [BYTE_W-1:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_REBOOT || c == CH_ECHO || c == CH_ABORT);
        return c;
    endfunction

    function automatic logic [63:0] pick_chars();
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
            v[i*8 +: 8] = pick_char();
        return v;
    endfunction

    // Control characters, digit neighbors or plain random bytes
    function automatic logic [BYTE_W-1:0] pick_noise();
        logic [BYTE_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = CH_ABORT;
            1:       c = CH_REBOOT;
            2:       c = CH_HEADER;
            3:       c = CH_PLUS;
            4:       c = CH_MINUS;
            5:       c = CH_ZERO - 8'd1;
            6:       c = CH_NINE + 8'd1;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Offer one word in bursts with random gaps; hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (b != CH_ECHO)
            sent_count++;
    endtask

    // Stop offering and wait until every result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write all four registers while idle; unused data bits carry junk
    task automatic apply_setting(input logic [REC_CNT_W-1:0] rc, input logic [FLD_CNT_W-1:0] fc,
                                 input logic [KEYS_W-1:0] keys, input logic [TAGS_W-1:0] tags);
        logic [63:0] junk;
        drain();
        junk = {$urandom, $urandom};
        write_reg(REG_RECORD_COUNT, {junk[63:REC_CNT_W], rc});
        write_reg(REG_FIELD_COUNT, {junk[63:FLD_CNT_W], fc});
        write_reg(REG_RECORD_KEYS, keys);
        write_reg(REG_FIELD_TAGS, {junk[63:TAGS_W], tags});
        i_cfg_valid   <= 1'b0;
        cur_rec_count = rc;
        cur_fld_count = fc;
        cur_keys      = keys;
        cur_tags      = tags;
        settings_count++;
    endtask

    // Build one frame: mostly well formed, some broken, some pure noise
    task automatic send_frame();
        logic [BYTE_W-1:0] fb[$];
        int n_rec, n_fld, roll, n_dig, pos;
        n_rec = (cur_rec_count > MAX_REC) ? MAX_REC : cur_rec_count;
        n_fld = (cur_fld_count > MAX_FLD) ? MAX_FLD : cur_fld_count;
        roll  = $urandom_range(0, 99);
        if (roll < 12) begin
            repeat ($urandom_range(1, 6)) fb.push_back(pick_noise());
        end else begin
            fb.push_back(($urandom_range(0, 9) == 0) ? pick_noise() : CH_HEADER);
            for (int r = 0; r < n_rec; r++) begin
                for (int f = 0; f < n_fld; f++) begin
                    fb.push_back(cur_keys[r*8 +: 8]);
                    fb.push_back(cur_tags[f*8 +: 8]);
                    // long runs push the magnitude into saturation
                    n_dig = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12)
                                                        : $urandom_range(0, 4);
                    repeat (n_dig) fb.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    fb.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                end
            end
            // break the frame at one random spot
            if (roll < 32) begin
                pos = $urandom_range(0, fb.size() - 1);
                fb[pos] = pick_noise();
            end
            // slip an echo request in; parsing must carry on around it
            if (roll >= 88) begin
                pos = $urandom_range(0, fb.size());
                fb.insert(pos, CH_ECHO);
            end
        end
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    // Output side: stall modes that change every so often, plus one long hold
    initial begin : receiver
        stall_mode_t mode;
        int mode_left;
        int hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 160);
            end
            mode_left--;
            if (hold_left == 0 && hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ((mode_left % 7) < 3);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0]    tail [15] = '{CH_MINUS, KEY_K, TAG_Q, CH_ZERO, CH_PLUS,
                                            CH_HEADER, KEY_K, TAG_Q,
                                            CH_HEADER, CH_ABORT,
                                            CH_HEADER, KEY_K, TAG_P, 8'hFF, CH_REBOOT};
        logic [REC_CNT_W-1:0] rc;
        logic [FLD_CNT_W-1:0] fc;
        logic [KEYS_W-1:0]    keys;
        logic [TAGS_W-1:0]    tags;
        int                   target;
        int                   directed_count;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one record of two fields keyed k with tags p and q
        apply_setting(4'd1, 3'd2, {56'd0, KEY_K}, {24'd0, TAG_Q, TAG_P});
        send_byte(CH_ECHO);
        send_byte(8'h00);
        send_byte(KEY_K);
        send_byte(TAG_P);
        repeat (10) send_byte(CH_NINE);
        foreach (tail[i]) send_byte(tail[i]);
        directed_count = sent_count;

        // Random frames under a series of settings
        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            rc   = 4'($urandom_range(1, MAX_REC));
            fc   = 3'($urandom_range(1, MAX_FLD));
            keys = pick_chars();
            tags = pick_chars();
            case (ph)
                0: begin rc = 4'(MAX_REC); fc = 3'(MAX_FLD); end
                1: rc = 4'd0;
                2: begin rc = 4'($urandom_range(0, 15)); fc = 3'd0; end
                3: begin rc = 4'd15; fc = 3'd7; end
                4: begin keys = '1; tags = '1; end
                5: begin keys = '0; tags = '0; end
                default: ;
            endcase
            apply_setting(rc, fc, keys, tags);
            // the largest setting is where the output gets held off
            if (ph == 0)
                hold_off_req = 1'b1;
            target = sent_count + ((ph == 1 || ph == 2) ? 50 : 212);
            while (sent_count < target) send_frame();
        end

        drain();
        $display("Sent %0d characters (%0d directed) under %0d register settings,",
                 sent_count, directed_count, settings_count);
        $display("including a %0d-cycle output hold-off; %0d result words checked, %0d values.",
                 HOLD_OFF_CYCLES, results_seen, values_seen);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
